>>> src/cvf_pkg.sv
// Shared constants, types and helpers of the camera view frame block.
// No dependencies; imported by camera_view_frame.
`timescale 1ns / 1ps
package cvf_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_BITS     = 30;
  localparam int CNT_W        = 5;
  localparam int VEC_W        = 66;
  localparam int ACC_W        = 67;
  localparam int QUO_W        = FRAC_BITS + 2;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_NABS   = 12'b000000000010,
    S_NSCALE = 12'b000000000100,
    S_NSQ    = 12'b000000001000,
    S_NSQRT  = 12'b000000010000,
    S_NDIV   = 12'b000000100000,
    S_CROSS  = 12'b000001000000,
    S_CORD   = 12'b000010000000,
    S_ROT    = 12'b000100000000,
    S_DOT    = 12'b001000000000,
    S_OUT    = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  typedef enum logic [3:0] {
    P_N1 = 4'b0001,
    P_C1 = 4'b0010,
    P_N2 = 4'b0100,
    P_C2 = 4'b1000
  } phase_t;

  function automatic logic signed [34:0] atan_q30(input logic [CNT_W-1:0] i);
    logic signed [34:0] a;
    begin
      case (i)
        5'd0:    a = 35'sd843314857;
        5'd1:    a = 35'sd497837828;
        5'd2:    a = 35'sd263043837;
        5'd3:    a = 35'sd133525159;
        5'd4:    a = 35'sd67021687;
        5'd5:    a = 35'sd33543516;
        5'd6:    a = 35'sd16775851;
        5'd7:    a = 35'sd8388437;
        5'd8:    a = 35'sd4194283;
        5'd9:    a = 35'sd2097149;
        5'd10:   a = 35'sd1048576;
        5'd11:   a = 35'sd524288;
        5'd12:   a = 35'sd262144;
        5'd13:   a = 35'sd131072;
        5'd14:   a = 35'sd65536;
        5'd15:   a = 35'sd32768;
        5'd16:   a = 35'sd16384;
        5'd17:   a = 35'sd8192;
        5'd18:   a = 35'sd4096;
        5'd19:   a = 35'sd2048;
        5'd20:   a = 35'sd1024;
        5'd21:   a = 35'sd512;
        5'd22:   a = 35'sd256;
        5'd23:   a = 35'sd128;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    begin
      hi = ACC_W'(32'sh7fffffff);
      lo = -ACC_W'(32'sh7fffffff) - ACC_W'(1);
      if (v > hi)      return 32'sh7fffffff;
      else if (v < lo) return 32'sh80000000;
      else             return v[31:0];
    end
  endfunction

  function automatic logic [1:0] next3(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

endpackage

>>> src/camera_view_frame.sv
// Camera view frame: keeps an orthonormal camera basis and eye, answers each
// request with the four rows of the inverse view matrix. Depends on cvf_pkg.
`timescale 1ns / 1ps
//
//  channel | dir | payload                                   | handshake
//  s_axis  | in  | tdata: eye, look, up xyz, roll_angle      | tvalid/tready
//          |     | tuser: func                               |
//  m_axis  | out | tdata: elem0..elem3; tuser: row, degen    | tvalid/tready, tlast
//
//  One request at a time; s_axis_tready is high only while idle.
//  Set: two normalizations (abs, scale, squares, square root and divide steps
//  each) and two cross products.
//  Roll: CORDIC iterations, then rotation of the right and up axes.
//  Both then compute the translation row, then four output rows.
//  All multiplies go through one registered 32x32 multiplier.
//  rst is synchronous; output stalls hold the current row.
module camera_view_frame (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] eye_x [63:32] eye_y [95:64] eye_z [127:96] look_x [159:128] look_y
  // [191:160] look_z [223:192] up_x [255:224] up_y [287:256] up_z
  // [306:288] roll_angle, rest zero
  input  logic [311:0] s_axis_tdata,
  // [0] func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] elem0 [63:32] elem1 [95:64] elem2 [127:96] elem3
  output logic [127:0] m_axis_tdata,
  // [1:0] row_index [2] degenerate
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import cvf_pkg::*;

  state_t state;
  phase_t phase;

  logic [CNT_W-1:0] cnt;
  logic [1:0]       k;
  logic             ph;
  logic             degen;
  logic [1:0]       row;

  // kept frame
  logic signed [31:0] right_axis [3];
  logic signed [31:0] up_axis    [3];
  logic signed [31:0] back_axis  [3];
  logic signed [31:0] eye_pos    [3];
  logic signed [31:0] dot        [3];

  // request and work registers
  logic signed [31:0]      in_eye [3];
  logic signed [31:0]      in_up  [3];
  logic signed [VEC_W-1:0] vec    [3];
  logic [VEC_W-1:0]        mag    [3];
  logic [VEC_W-1:0]        big;
  logic signed [31:0]      nn     [3];
  logic signed [31:0]      nrm    [3];
  logic [63:0]             sum;
  logic [63:0]             sq_x;
  logic [63:0]             sq_r;
  logic [31:0]             len;
  logic [32:0]             rem;
  logic [QUO_W-1:0]        quo;
  logic signed [33:0]      cx, cy;
  logic signed [34:0]      cz;
  logic                    flip;
  logic signed [31:0]      cos_v, sin_v;
  logic signed [ACC_W-1:0] acc, acc2;

  // shared multiplier
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;

  // input unpack
  logic signed [31:0] s_eye [3];
  logic signed [31:0] s_look[3];
  logic signed [31:0] s_up  [3];
  logic signed [18:0] s_ang;
  logic signed [34:0] zz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_eye[i]  = $signed(s_axis_tdata[32*i +: 32]);
      s_look[i] = $signed(s_axis_tdata[96 + 32*i +: 32]);
      s_up[i]   = $signed(s_axis_tdata[192 + 32*i +: 32]);
    end
    s_ang = $signed(s_axis_tdata[306:288]);
    zz    = 35'(s_ang) <<< (ANG_BITS - 16);
  end

  // cross operand selection: one index per array per cycle
  logic [1:0]         k1, k2, ia, ib;
  logic signed [31:0] ca, cb;

  always_comb begin
    k1 = next3(k);
    k2 = next3(k1);
    ia = cnt[0] ? k2 : k1;
    ib = cnt[0] ? k1 : k2;
    if (phase == P_C2) begin
      ca = nn[ia];
      cb = nrm[ib];
    end else begin
      ca = in_up[ia];
      cb = nn[ib];
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_NSQ: begin
        ma = $signed(mag[k][31:0]);
        mb = $signed(mag[k][31:0]);
      end
      S_CROSS: begin
        ma = ca;
        mb = cb;
      end
      S_ROT: begin
        ma = (cnt[1:0] == 2'd1 || cnt[1:0] == 2'd2) ? up_axis[k] : right_axis[k];
        mb = (cnt[1:0] == 2'd0 || cnt[1:0] == 2'd2) ? cos_v : sin_v;
      end
      S_DOT: begin
        ma = eye_pos[cnt[1:0]];
        mb = (k == 2'd0) ? right_axis[cnt[1:0]] :
             (k == 2'd1) ? up_axis[cnt[1:0]] : back_axis[cnt[1:0]];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // datapath step values
  logic [VEC_W-1:0]        mag_c [3];
  logic [VEC_W-1:0]        big_c;
  logic [63:0]             sum_next;
  logic [63:0]             bitv, sq_t, sq_r_next;
  logic                    sq_ge;
  logic [33:0]             dv_t;
  logic                    dv_ge;
  logic [32:0]             rem_next;
  logic [QUO_W-1:0]        quo_next;
  logic signed [31:0]      q_val, q_signed;
  logic signed [ACC_W-1:0] diff, rsum, rdiff, dsum;
  logic signed [33:0]      dx, dy;

  always_comb begin
    for (int i = 0; i < 3; i++)
      mag_c[i] = vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
    big_c = mag_c[0];
    if (mag_c[1] > big_c) big_c = mag_c[1];
    if (mag_c[2] > big_c) big_c = mag_c[2];

    sum_next = ((k == 2'd0) ? 64'd0 : sum) + 64'(prod);

    bitv      = 64'd1 << {cnt, 1'b0};
    sq_t      = sq_r + bitv;
    sq_ge     = sq_x >= sq_t;
    sq_r_next = sq_ge ? (sq_r >> 1) + bitv : sq_r >> 1;

    dv_t     = (cnt == '0) ? {4'd0, mag[k][29:1], mag[k][0]} : {rem, 1'b0};
    dv_ge    = dv_t >= 34'(len);
    rem_next = dv_ge ? 33'(dv_t - 34'(len)) : dv_t[32:0];
    quo_next = {((cnt == '0) ? QUO_W'(0) : quo) << 1} | QUO_W'(dv_ge);
    q_val    = 32'(quo_next);
    q_signed = vec[k][VEC_W-1] ? -q_val : q_val;

    diff  = acc - ACC_W'(prod);
    rsum  = acc + ACC_W'(prod);
    rdiff = acc2 - ACC_W'(prod);
    dsum  = ((cnt == '0) ? ACC_W'(0) : acc) + ACC_W'(prod >>> FRAC_BITS);

    dx = cy >>> cnt;
    dy = cx >>> cnt;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_N1;
      cnt   <= '0;
      k     <= '0;
      ph    <= 1'b0;
      degen <= 1'b0;
      row   <= '0;
      for (int i = 0; i < 3; i++) begin
        right_axis[i] <= '0;
        up_axis[i]    <= '0;
        back_axis[i]  <= '0;
        eye_pos[i]    <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          k   <= '0;
          ph  <= 1'b0;
          row <= '0;
          if (s_axis_tvalid) begin
            degen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              in_eye[i] <= s_eye[i];
              in_up[i]  <= s_up[i];
              vec[i]    <= VEC_W'(s_eye[i]) - VEC_W'(s_look[i]);
            end
            cx <= 34'(CORDIC_GAIN);
            cy <= '0;
            if (zz > HALF_PI_Q30) begin
              cz   <= zz - PI_Q30;
              flip <= 1'b1;
            end else if (zz < -HALF_PI_Q30) begin
              cz   <= zz + PI_Q30;
              flip <= 1'b1;
            end else begin
              cz   <= zz;
              flip <= 1'b0;
            end
            phase <= P_N1;
            state <= s_axis_tuser ? S_CORD : S_NABS;
          end
        end

        S_NABS: begin
          for (int i = 0; i < 3; i++) mag[i] <= mag_c[i];
          big <= big_c;
          k   <= '0;
          ph  <= 1'b0;
          cnt <= '0;
          if (big_c == '0) begin
            // degenerate: keep the frame, emit it flagged
            degen <= 1'b1;
            state <= S_DOT;
          end else begin
            state <= S_NSCALE;
          end
        end

        S_NSCALE: begin
          if (|big[VEC_W-1:30]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
            big <= big >> 1;
          end else if (!big[29]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
            big <= big << 1;
          end else begin
            state <= S_NSQ;
          end
        end

        S_NSQ: begin
          ph <= ~ph;
          if (ph) begin
            sum <= sum_next;
            if (k == 2'd2) begin
              sq_x  <= sum_next;
              sq_r  <= '0;
              cnt   <= CNT_W'(31);
              state <= S_NSQRT;
            end else begin
              k <= k + 2'd1;
            end
          end
        end

        S_NSQRT: begin
          if (sq_ge) sq_x <= sq_x - sq_t;
          sq_r <= sq_r_next;
          if (cnt == '0) begin
            len   <= sq_r_next[31:0];
            k     <= '0;
            state <= S_NDIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_NDIV: begin
          rem <= rem_next;
          quo <= quo_next;
          if (cnt == CNT_W'(FRAC_BITS)) begin
            cnt <= '0;
            if (phase == P_N1) nn[k] <= q_signed;
            else nrm[k] <= q_signed;
            if (k == 2'd2) begin
              k     <= '0;
              ph    <= 1'b0;
              phase <= (phase == P_N1) ? P_C1 : P_C2;
              state <= S_CROSS;
            end else begin
              k <= k + 2'd1;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_CROSS: begin
          ph <= ~ph;
          if (ph) begin
            if (cnt[0] == 1'b0) begin
              acc    <= ACC_W'(prod);
              cnt[0] <= 1'b1;
            end else begin
              cnt[0] <= 1'b0;
              vec[k] <= VEC_W'(diff);
              if (phase == P_C2) up_axis[k] <= sat32(diff >>> FRAC_BITS);
              if (k == 2'd2) begin
                k   <= '0;
                cnt <= '0;
                if (phase == P_C1) begin
                  phase <= P_N2;
                  state <= S_NABS;
                end else begin
                  // commit the new frame
                  for (int i = 0; i < 3; i++) begin
                    right_axis[i] <= nrm[i];
                    back_axis[i]  <= nn[i];
                    eye_pos[i]    <= in_eye[i];
                  end
                  state <= S_DOT;
                end
              end else begin
                k <= k + 2'd1;
              end
            end
          end
        end

        S_CORD: begin
          if (cnt == CNT_W'(CORDIC_STEPS)) begin
            cos_v <= flip ? -cx[31:0] : cx[31:0];
            sin_v <= flip ? -cy[31:0] : cy[31:0];
            cnt   <= '0;
            k     <= '0;
            ph    <= 1'b0;
            state <= S_ROT;
          end else begin
            if (!cz[34]) begin
              cx <= cx - dx;
              cy <= cy + dy;
              cz <= cz - atan_q30(cnt);
            end else begin
              cx <= cx + dx;
              cy <= cy - dy;
              cz <= cz + atan_q30(cnt);
            end
            cnt <= cnt + 1'b1;
          end
        end

        S_ROT: begin
          ph <= ~ph;
          if (ph) begin
            case (cnt[1:0])
              2'd0: acc  <= ACC_W'(prod);
              2'd1: acc  <= rsum;
              2'd2: acc2 <= ACC_W'(prod);
              default: begin
                up_axis[k]    <= sat32(rdiff >>> ANG_BITS);
                right_axis[k] <= sat32(acc >>> ANG_BITS);
              end
            endcase
            if (cnt[1:0] == 2'd3) begin
              cnt <= '0;
              if (k == 2'd2) begin
                k     <= '0;
                state <= S_DOT;
              end else begin
                k <= k + 2'd1;
              end
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end

        S_DOT: begin
          ph <= ~ph;
          if (ph) begin
            acc <= dsum;
            if (cnt == CNT_W'(2)) begin
              dot[k] <= sat32(-dsum);
              cnt    <= '0;
              if (k == 2'd2) begin
                row   <= '0;
                state <= S_OUT;
              end else begin
                k <= k + 2'd1;
              end
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end

        S_OUT: begin
          if (m_axis_tready) begin
            if (row == 2'd3) state <= S_IDLE;
            else row <= row + 2'd1;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output rows come straight from the held frame
  logic signed [31:0] e0, e1, e2, e3;

  always_comb begin
    if (row == 2'd3) begin
      e0 = dot[0];
      e1 = dot[1];
      e2 = dot[2];
      e3 = 32'sd1 <<< FRAC_BITS;
    end else begin
      e0 = right_axis[row];
      e1 = up_axis[row];
      e2 = back_axis[row];
      e3 = '0;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {e3, e2, e1, e0};
  assign m_axis_tuser  = {degen, row};
  assign m_axis_tlast  = (row == 2'd3);

endmodule

>>> src/cvf_checker.sv
// Port-level checker for camera_view_frame, bound to the top level.
// Depends on the top-level ports only.
`timescale 1ns / 1ps
module cvf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new request taken while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open while rows pending");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == 2'd3)))
    else $error("tlast not on row three");

  a_end_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("rows continue after last");

endmodule

bind camera_view_frame cvf_checker u_cvf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
